FILE: sv/priority_channel_table_core_macros.svh
// Assertion shorthands shared by the table core.
`ifndef PRIORITY_CHANNEL_TABLE_CORE_MACROS_SVH
`define PRIORITY_CHANNEL_TABLE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/pct_pkg.sv
package pct_pkg;

   // table geometry
   localparam int NUM_SLOTS     = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int QUEUE_DEPTH   = 2;

   localparam int SLOT_W  = $clog2(NUM_SLOTS);
   localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   // word field widths
   localparam int OPCODE_W   = 2;
   localparam int PRI_REQ_W  = 16;
   localparam int SLOT_IN_W  = 4;
   localparam int SLOT_OUT_W = 4;
   localparam int STATUS_W   = 2;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CHANGE = 2'd2,
      OP_PASS   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_FREE  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EMIT,
      BK_DONE
   } back_state_type;

   // decoded command as it travels through the queue
   typedef struct packed {
      op_type                   op;
      logic                     slot_ok;
      logic [SLOT_W-1:0]        slot_idx;
      logic [SLOT_OUT_W-1:0]    slot_raw;
      logic [PRIORITY_BITS-1:0] pri;
      logic                     motion;
      logic                     cls;
   } cmd_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

endpackage

FILE: sv/pct_if.sv
interface pct_req_if;
   import pct_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [PRI_REQ_W-1:0] priority_req;
   logic                 has_motion;
   logic                 blended;
   logic [SLOT_IN_W-1:0] slot;

   modport source (output valid, opcode, priority_req, has_motion, blended, slot,
                   input ready);
   modport sink   (input valid, opcode, priority_req, has_motion, blended, slot,
                   output ready);
endinterface

interface pct_rsp_if;
   import pct_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SLOT_OUT_W-1:0] slot_out;
   logic [STATUS_W-1:0]   status;
   logic                  last;

   modport source (output valid, slot_out, status, last, input ready);
   modport sink   (input valid, slot_out, status, last, output ready);
endinterface

FILE: sv/pct_front.sv
module pct_front (
   pct_req_if.sink                req,
   input  pct_pkg::q_status_type  q_status,
   output logic                   push,
   output pct_pkg::cmd_type       cmd
);
   import pct_pkg::*;

   assign req.ready = !q_status.full;
   assign push      = req.valid && !q_status.full;

   // decode and range-check the word before it is queued
   always_comb begin
      cmd.op       = op_type'(req.opcode);
      cmd.slot_ok  = (32'(req.slot) < 32'(NUM_SLOTS));
      cmd.slot_idx = SLOT_W'(req.slot);
      cmd.slot_raw = SLOT_OUT_W'(req.slot);
      cmd.pri      = PRIORITY_BITS'(req.priority_req);
      cmd.motion   = req.has_motion;
      cmd.cls      = req.blended;
   end

endmodule

FILE: sv/pct_queue.sv
module pct_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pct_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output pct_pkg::q_status_type q_status,
   output pct_pkg::cmd_type      head_cmd
);
   import pct_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign head_cmd       = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/pct_back.sv
`include "priority_channel_table_core_macros.svh"

module pct_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pct_pkg::q_status_type q_status,
   input  pct_pkg::cmd_type      q_cmd,
   output logic                  q_pop,
   pct_rsp_if.source             rsp
);
   import pct_pkg::*;

   // slot table
   logic [NUM_SLOTS-1:0]     valid_ff, valid_in;
   logic [NUM_SLOTS-1:0]     processed_ff, processed_in;
   logic [PRIORITY_BITS-1:0] pri_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]     motion_ff;
   logic [NUM_SLOTS-1:0]     blended_ff;

   // table write port
   logic                     tbl_we;
   logic [SLOT_W-1:0]        tbl_idx;
   logic [PRIORITY_BITS-1:0] tbl_pri;
   logic                     tbl_motion;
   logic                     tbl_cls;

   // pass sequencer
   back_state_type           state_ff, state_in;
   logic [SLOT_W-1:0]        idx_ff, idx_in;
   logic [SLOT_W-1:0]        best_ff, best_in;
   logic [PRIORITY_BITS-1:0] best_pri_ff, best_pri_in;
   logic                     found_ff, found_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SLOT_W-1:0]        held_ff, held_in;
   logic                     cls_ff, cls_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SLOT_OUT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_free;
   logic                     any_free;
   logic [SLOT_W-1:0]        free_idx;
   logic                     joins;
   logic                     cand;
   logic                     take;
   logic                     start;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign start    = q_status.valid && out_free;

   // lowest free slot
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // scanned slot: <= lets a later slot of equal priority win
   assign joins = valid_ff[idx_ff] &&
                  (motion_ff[idx_ff] ? (blended_ff[idx_ff] == cls_ff) : !cls_ff);
   assign cand  = joins && !processed_ff[idx_ff] &&
                  (!found_ff || (pri_ff[idx_ff] <= best_pri_ff));
   assign take  = found_ff && ((cnt_ff == '0) || out_free);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start && (q_cmd.op == OP_PASS)) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (idx_ff == LAST_SLOT) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (!found_ff) begin
               state_in = BK_DONE;
            end else if (take) begin
               state_in = (cnt_ff + 1'b1 == CNT_W'(MAX_RESULTS)) ? BK_DONE : BK_SCAN;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      valid_in      = valid_ff;
      processed_in  = processed_ff;
      tbl_we        = 1'b0;
      tbl_idx       = q_cmd.slot_idx;
      tbl_pri       = q_cmd.pri;
      tbl_motion    = q_cmd.motion;
      tbl_cls       = q_cmd.cls;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_pri_in   = best_pri_ff;
      found_in      = found_ff;
      cnt_in        = cnt_ff;
      held_in       = held_ff;
      cls_in        = cls_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (start) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (any_free) begin
                        valid_in[free_idx] = 1'b1;
                        tbl_we             = 1'b1;
                        tbl_idx            = free_idx;
                        rsp_slot_in        = SLOT_OUT_W'(free_idx);
                        rsp_status_in      = ST_OK;
                     end else begin
                        rsp_slot_in   = '0;
                        rsp_status_in = ST_FULL;
                     end
                  end
                  OP_REMOVE, OP_CHANGE: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_slot_in  = q_cmd.slot_raw;
                     if (q_cmd.slot_ok && valid_ff[q_cmd.slot_idx]) begin
                        rsp_status_in = ST_OK;
                        if (q_cmd.op == OP_REMOVE) begin
                           valid_in[q_cmd.slot_idx] = 1'b0;
                        end else begin
                           tbl_we = 1'b1;
                        end
                     end else begin
                        rsp_status_in = ST_FREE;
                     end
                  end
                  OP_PASS: begin
                     processed_in = '0;
                     cnt_in       = '0;
                     idx_in       = '0;
                     found_in     = 1'b0;
                     cls_in       = q_cmd.cls;
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (cand) begin
               found_in    = 1'b1;
               best_in     = idx_ff;
               best_pri_in = pri_ff[idx_ff];
            end
            idx_in = (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
         end
         BK_EMIT: begin
            if (take) begin
               // the earlier pick is not the final one: let it go
               if (cnt_ff != '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = SLOT_OUT_W'(held_ff);
                  rsp_status_in = ST_OK;
                  rsp_last_in   = 1'b0;
               end
               held_in               = best_ff;
               processed_in[best_ff] = 1'b1;
               cnt_in                = cnt_ff + 1'b1;
               found_in              = 1'b0;
               idx_in                = '0;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (cnt_ff != '0) begin
                  rsp_slot_in   = SLOT_OUT_W'(held_ff);
                  rsp_status_in = ST_OK;
               end else begin
                  rsp_slot_in   = '0;
                  rsp_status_in = ST_EMPTY;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         processed_ff <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         processed_ff <= processed_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff       <= best_in;
      best_pri_ff   <= best_pri_in;
      held_ff       <= held_in;
      cls_ff        <= cls_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (tbl_we) begin
         pri_ff[tbl_idx]     <= tbl_pri;
         motion_ff[tbl_idx]  <= tbl_motion;
         blended_ff[tbl_idx] <= tbl_cls;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.slot_out = rsp_slot_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.last     = rsp_last_ff;

   `PCT_ASSERT_SAME(a_scan_cnt, clock, reset, (state_ff == BK_SCAN), (cnt_ff < CNT_W'(MAX_RESULTS)), "pass scan running past result limit")
   `PCT_ASSERT_SAME(a_pick_count, clock, reset, (state_ff != BK_IDLE), ($countones(processed_ff) == 32'(cnt_ff)), "picked slots out of step with pass count")
   `PCT_ASSERT_NEXT(a_add_fill, clock, reset, (tbl_we && (state_ff == BK_IDLE) && (q_cmd.op == OP_ADD)), valid_ff[$past(tbl_idx)], "added slot not marked valid")

endmodule

FILE: sv/priority_channel_table_core.sv
// Priority channel table: sixteen slots, each holding a 16-bit priority, a has-motion
// flag and a blended flag. Add takes the lowest free slot and reports it (or table
// full); remove and change act on a valid slot and report a free one. A pass word
// for one class returns every valid slot of that class, lowest priority value
// first, the higher slot first on a tie, last set on the final word; an entry
// without motion only joins the non-blended pass, and an empty pass gives a single
// word with status "found nothing". Words are decoded by the front end and
// sit in a two-deep queue; add, remove and change are then done by the back
// end from its idle state. A pass walks the slot store one slot per cycle for
// each result (a full scan, then a pick step); a pass that returns all sixteen
// slots stops at the result limit without a closing empty scan. Output stalls
// lengthen a pass. The request side keeps taking words into the queue while a
// pass runs, until the queue is full; a result waiting in the output register
// holds back the start of the next operation until it is taken.
module priority_channel_table_core (
   input  logic      clock,
   input  logic      reset,
   pct_req_if.sink   req_chan,
   pct_rsp_if.source rsp_chan
);
   import pct_pkg::*;

   // front end to queue
   logic         push;
   cmd_type      push_cmd;

   // queue to back end
   q_status_type q_status;
   cmd_type      head_cmd;
   logic         pop;

   // decode only, no storage
   pct_front u_front (
      .req      (req_chan),
      .q_status (q_status),
      .push     (push),
      .cmd      (push_cmd)
   );

   // decouples word intake from table operations
   pct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status),
      .head_cmd (head_cmd)
   );

   // slot store, pass sequencer and output register
   pct_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_cmd    (head_cmd),
      .q_pop    (pop),
      .rsp      (rsp_chan)
   );

endmodule

FILE: tb/sv/pct_order_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow of the slot table and checks every
// response word against the oldest predicted one.
module pct_order_checker (
   input  logic clock,
   input  logic reset,
   pct_req_if   req_mon,
   pct_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   import pct_pkg::*;

   typedef struct {
      logic [SLOT_OUT_W-1:0] slot_out;
      status_type            status;
      logic                  last;
   } rsp_word_type;

   logic                     shadow_valid  [NUM_SLOTS];
   logic [PRIORITY_BITS-1:0] shadow_pri    [NUM_SLOTS];
   logic                     shadow_motion [NUM_SLOTS];
   logic                     shadow_cls    [NUM_SLOTS];

   rsp_word_type expected_words [$];
   int           mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic joins_class(int i, logic cls);
      if (!shadow_valid[i])
         return 1'b0;
      if (shadow_motion[i])
         return shadow_cls[i] == cls;
      return !cls;
   endfunction

   function automatic void push_word(int slot_val, status_type st, logic last);
      rsp_word_type w;
      w.slot_out = SLOT_OUT_W'(slot_val);
      w.status   = st;
      w.last     = last;
      expected_words.push_back(w);
   endfunction

   function automatic void predict_word(op_type op, logic [PRI_REQ_W-1:0] pri,
                                        logic motion, logic cls,
                                        logic [SLOT_IN_W-1:0] s);
      int                       best;
      int                       n;
      int                       free_idx;
      logic [PRIORITY_BITS-1:0] best_pri;
      logic                     taken [NUM_SLOTS];
      case (op)
         OP_ADD: begin
            free_idx = -1;
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
               if (!shadow_valid[i])
                  free_idx = i;
            if (free_idx < 0) begin
               push_word(0, ST_FULL, 1'b1);
            end else begin
               shadow_valid[free_idx]  = 1'b1;
               shadow_pri[free_idx]    = PRIORITY_BITS'(pri);
               shadow_motion[free_idx] = motion;
               shadow_cls[free_idx]    = cls;
               push_word(free_idx, ST_OK, 1'b1);
            end
         end
         OP_REMOVE, OP_CHANGE: begin
            if (int'(s) >= NUM_SLOTS || !shadow_valid[s]) begin
               push_word(int'(s), ST_FREE, 1'b1);
            end else begin
               if (op == OP_REMOVE) begin
                  shadow_valid[s] = 1'b0;
               end else begin
                  shadow_pri[s]    = PRIORITY_BITS'(pri);
                  shadow_motion[s] = motion;
                  shadow_cls[s]    = cls;
               end
               push_word(int'(s), ST_OK, 1'b1);
            end
         end
         default: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               taken[i] = 1'b0;
            n = 0;
            while (n < MAX_RESULTS) begin
               best     = -1;
               best_pri = '0;
               // <= lets the higher slot win a tie
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (joins_class(i, cls) && !taken[i] &&
                      (best < 0 || shadow_pri[i] <= best_pri)) begin
                     best     = i;
                     best_pri = shadow_pri[i];
                  end
               if (best < 0)
                  break;
               taken[best] = 1'b1;
               push_word(best, ST_OK, 1'b0);
               n++;
            end
            if (n == 0)
               push_word(0, ST_EMPTY, 1'b1);
            else
               expected_words[expected_words.size() - 1].last = 1'b1;
         end
      endcase
   endfunction

   rsp_word_type want;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_valid[i]  = 1'b0;
            shadow_pri[i]    = '0;
            shadow_motion[i] = 1'b0;
            shadow_cls[i]    = 1'b0;
         end
         expected_words.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_word(op_type'(req_mon.opcode), req_mon.priority_req,
                         req_mon.has_motion, req_mon.blended, req_mon.slot);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: slot_out %0d status %0d last %0d",
                      rsp_mon.slot_out, rsp_mon.status, rsp_mon.last);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.slot_out !== want.slot_out) begin
                  $error("slot_out: expected %0d, actual %0d",
                         want.slot_out, rsp_mon.slot_out);
                  mismatches++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_mon.status);
                  mismatches++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0d, actual %0d",
                         want.last, rsp_mon.last);
                  mismatches++;
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the priority channel table. The checker beside the
// block does all prediction; this module only feeds words and drains results.
module tb_top;
   import pct_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;

   pct_req_if req ();
   pct_rsp_if rsp ();

   priority_channel_table_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req.sink),
      .rsp_chan (rsp.source)
   );

   pct_order_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req),
      .rsp_mon    (rsp),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop: with roughly 250 words in the worst case, the timeout leaves a
   // wide margin
   initial begin
      #2_000_000;
      $display("priority_channel_table_core regression: fail");
      $finish;
   end

   // Drive one request word. Called at a falling edge; returns at the falling
   // edge after the word was taken, valid still high so a back-to-back word
   // needs only one assignment.
   task automatic send_word(op_type op, logic [PRI_REQ_W-1:0] pri, logic motion,
                            logic cls, logic [SLOT_IN_W-1:0] slot_idx);
      int gap;
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.opcode       <= op;
      req.priority_req <= pri;
      req.has_motion   <= motion;
      req.blended      <= cls;
      req.slot         <= slot_idx;
      req.valid        <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Priority mix: small values for lots of ties, a share of the extremes,
   // the rest anywhere in the range.
   function automatic logic [PRI_REQ_W-1:0] draw_priority();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return PRI_REQ_W'($urandom_range(0, 3));
      if (r == 3)
         return $urandom_range(0, 1) ? '1 : '0;
      return PRI_REQ_W'($urandom);
   endfunction

   // Random phase: weights in percent for add, remove and change; passes
   // take what is left.
   task automatic run_phase(int count, int add_w, int rem_w, int chg_w);
      int     r;
      op_type op;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < add_w)
            op = OP_ADD;
         else if (r < add_w + rem_w)
            op = OP_REMOVE;
         else if (r < add_w + rem_w + chg_w)
            op = OP_CHANGE;
         else
            op = OP_PASS;
         // unused fields stay random so the block is seen to ignore them
         send_word(op, draw_priority(), 1'($urandom), 1'($urandom),
                   SLOT_IN_W'($urandom_range(0, NUM_SLOTS - 1)));
      end
   endtask

   // Response side: a random hold-off before each word.
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, 9);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      logic [PRI_REQ_W-1:0] pri;
      req.valid        = 1'b0;
      req.opcode       = OP_ADD;
      req.priority_req = '0;
      req.has_motion   = 1'b0;
      req.blended      = 1'b0;
      req.slot         = '0;
      reset            = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      // empty table: both passes find nothing, remove and change hit free slots
      send_word(OP_PASS,   16'h1234, 1'b0, 1'b0, 4'd3);
      send_word(OP_PASS,   16'h0000, 1'b1, 1'b1, 4'd0);
      send_word(OP_REMOVE, 16'h0000, 1'b0, 1'b0, 4'd0);
      send_word(OP_CHANGE, 16'hFFFF, 1'b1, 1'b1, 4'd15);

      // fill all sixteen slots: extremes first, then three-way priority ties,
      // every motion/class combination including no-motion with blended set
      for (int i = 0; i < NUM_SLOTS; i++) begin
         pri = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
               PRI_REQ_W'(i % 3) * 16'h5555;
         send_word(OP_ADD, pri, 1'(i), 1'(i >> 1), 4'd0);
      end
      // table full
      send_word(OP_ADD, 16'h7777, 1'b1, 1'b0, 4'd0);

      // ordered passes over a full table, one per class
      send_word(OP_PASS, 16'h0000, 1'b0, 1'b0, 4'd0);
      send_word(OP_PASS, 16'hFFFF, 1'b1, 1'b1, 4'd15);

      // change a live slot, remove it, then remove it again when free
      send_word(OP_CHANGE, 16'h0000, 1'b1, 1'b1, 4'd15);
      send_word(OP_REMOVE, 16'hFFFF, 1'b0, 1'b0, 4'd15);
      send_word(OP_REMOVE, 16'hABCD, 1'b1, 1'b0, 4'd15);

      // --- random ---
      run_phase(48, 20, 40, 15);   // drain heavy from a full table
      run_phase(48, 45, 20, 15);   // refill
      run_phase(48, 30, 30, 15);   // balanced
      run_phase(48, 35, 25, 15);

      req.valid <= 1'b0;

      // drain outstanding words, then give a full-table pass time to show
      // anything stray
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);

      if (fail_count == 0)
         $display("priority_channel_table_core regression: pass");
      else
         $display("priority_channel_table_core regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/pct_pkg.sv
sv/pct_if.sv
sv/pct_front.sv
sv/pct_queue.sv
sv/pct_back.sv
sv/priority_channel_table_core.sv
tb/sv/pct_order_checker.sv
tb/sv/tb_top.sv
